### rtl/core/trsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trsa_pkg: shared types and constants for the small-modulus RSA block.
// Holds the field widths, the register indexes, the status codes, the
// sequencer states and the request and response types of the divider.
// ----------------------------------------------------------------------------
package trsa_pkg;

    localparam int MOD_BITS = 16;
    localparam int WIDE_BITS = 2 * MOD_BITS;
    localparam int CNT_BITS = $clog2(WIDE_BITS + 1);
    localparam int PF_BITS = 8;
    localparam int Q_BITS = 15;

    localparam logic [MOD_BITS-1:0] RST_MODULUS = MOD_BITS'(3233);
    localparam logic [MOD_BITS-1:0] RST_EXPONENT = MOD_BITS'(17);

    localparam logic [0:0] REG_MODULUS = 1'b0;
    localparam logic [0:0] REG_EXPONENT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_NO_FACTOR = 2'd1,
        ST_NO_INVERSE = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_E_INIT,
        S_E_MUL_ACC,
        S_E_MUL_BASE,
        S_E_NEXT,
        S_F_INIT,
        S_F_SQ,
        S_F_DIV,
        S_F_STRIP,
        S_F_NEXT,
        S_Q_DIV,
        S_I_INIT,
        S_I_MUL,
        S_I_NEXT,
        S_D_INIT,
        S_D_MUL_ACC,
        S_D_MUL_BASE,
        S_D_NEXT,
        S_OUT
    } t_state;

    // Request to the shared divider.
    typedef struct packed {
        logic                 start;
        logic [WIDE_BITS-1:0] num;
        logic [MOD_BITS-1:0]  den;
    } t_div_req;

    // Response of the shared unit.
    typedef struct packed {
        logic                 done;
        logic [WIDE_BITS-1:0] quo;
        logic [WIDE_BITS-1:0] rem;
    } t_div_rsp;

endpackage
`default_nettype wire

### rtl/core/trsa_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trsa_divider: radix-2 restoring divider.
// Divides a 32-bit numerator by a 16-bit divisor, one quotient bit per
// cycle. A zero divisor gives the low 17 bits of the numerator as the
// remainder.
// ----------------------------------------------------------------------------
module trsa_divider (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  trsa_pkg::t_div_req      i_req,
    output trsa_pkg::t_div_rsp      o_rsp
);
    import trsa_pkg::*;

    logic [WIDE_BITS-1:0] r_quo, n_quo;
    logic [MOD_BITS:0]    r_rem, n_rem;
    logic [MOD_BITS-1:0]  r_den, n_den;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [MOD_BITS+1:0]  w_shift;
    logic [MOD_BITS+1:0]  w_diff;

    // One shift and subtract step per cycle.
    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        n_den = r_den;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_shift = {r_rem, r_quo[WIDE_BITS-1]};
        w_diff = w_shift - {2'b00, r_den};
        if (i_req.start) begin
            n_quo = i_req.num;
            n_rem = '0;
            n_den = i_req.den;
            n_cnt = CNT_BITS'(WIDE_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[MOD_BITS+1]) begin
                n_rem = w_diff[MOD_BITS:0];
                n_quo = {r_quo[WIDE_BITS-2:0], 1'b1};
            end else begin
                n_rem = w_shift[MOD_BITS:0];
                n_quo = {r_quo[WIDE_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo = r_quo;
    assign o_rsp.rem = {{(WIDE_BITS-MOD_BITS-1){1'b0}}, r_rem};

endmodule
`default_nettype wire

### rtl/core/trsa_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trsa_seq: sequencer for key derivation and both exponentiations.
// Runs the encryption, the trial division, the inverse search and the
// decryption in turn, each reduction or remainder done by the divider.
// ----------------------------------------------------------------------------
module trsa_seq (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire  [trsa_pkg::MOD_BITS-1:0]    i_msg,
    input  wire  [trsa_pkg::MOD_BITS-1:0]    i_n,
    input  wire  [trsa_pkg::MOD_BITS-1:0]    i_e,
    input  wire                              i_take,
    output logic                             o_busy,
    output logic                             o_valid,
    output logic [trsa_pkg::PF_BITS-1:0]     o_p,
    output logic [trsa_pkg::Q_BITS-1:0]      o_q,
    output logic [trsa_pkg::MOD_BITS-1:0]    o_d,
    output logic [trsa_pkg::MOD_BITS-1:0]    o_c,
    output logic [trsa_pkg::MOD_BITS-1:0]    o_m,
    output trsa_pkg::t_status                o_status
);
    import trsa_pkg::*;

    t_state r_state, n_state;
    t_div_req w_req;
    t_div_rsp w_rsp;

    logic [MOD_BITS-1:0] r_n, n_n, r_e, n_e;
    logic [MOD_BITS-1:0] r_acc, n_acc, r_base, n_base, r_ex, n_ex;
    logic [MOD_BITS-1:0] r_c, n_c, r_x, n_x, r_rest, n_rest;
    logic [MOD_BITS-1:0] r_p, n_p, r_q, n_q, r_phi, n_phi, r_i, n_i, r_d, n_d;
    logic [MOD_BITS-1:0] r_m, n_m;
    t_status r_st, n_st;
    logic r_wait, n_wait;
    logic [WIDE_BITS-1:0] w_sq;

    trsa_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_sq = WIDE_BITS'(r_x) * WIDE_BITS'(r_x);

    // Next state and datapath; each divider call starts once, then waits.
    always_comb begin
        n_state = r_state;
        n_n = r_n; n_e = r_e; n_acc = r_acc; n_base = r_base; n_ex = r_ex;
        n_c = r_c; n_x = r_x; n_rest = r_rest; n_p = r_p; n_q = r_q;
        n_phi = r_phi; n_i = r_i; n_d = r_d; n_m = r_m; n_st = r_st;
        n_wait = r_wait;
        w_req.start = 1'b0;
        w_req.num = '0;
        w_req.den = r_n;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_n = i_n;
                    n_e = i_e;
                    n_base = i_msg;
                    n_ex = i_e;
                    n_state = S_E_INIT;
                end
            end
            S_E_INIT, S_D_INIT: begin
                // Reduce the base modulo n; the accumulator starts at 1 mod n.
                w_req.num = WIDE_BITS'(r_base);
                if (!r_wait) begin
                    w_req.start = 1'b1;
                    n_wait = 1'b1;
                end else if (w_rsp.done) begin
                    n_wait = 1'b0;
                    n_base = w_rsp.rem[MOD_BITS-1:0];
                    n_acc = (r_n == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                    n_state = (r_state == S_E_INIT) ? S_E_NEXT : S_D_NEXT;
                end
            end
            S_E_MUL_ACC, S_D_MUL_ACC: begin
                w_req.num = WIDE_BITS'(r_acc) * WIDE_BITS'(r_base);
                if (!r_wait) begin
                    w_req.start = 1'b1;
                    n_wait = 1'b1;
                end else if (w_rsp.done) begin
                    n_wait = 1'b0;
                    n_acc = w_rsp.rem[MOD_BITS-1:0];
                    n_state = (r_state == S_E_MUL_ACC) ? S_E_MUL_BASE : S_D_MUL_BASE;
                end
            end
            S_E_MUL_BASE, S_D_MUL_BASE: begin
                w_req.num = WIDE_BITS'(r_base) * WIDE_BITS'(r_base);
                if (!r_wait) begin
                    w_req.start = 1'b1;
                    n_wait = 1'b1;
                end else if (w_rsp.done) begin
                    n_wait = 1'b0;
                    n_base = w_rsp.rem[MOD_BITS-1:0];
                    n_ex = r_ex >> 1;
                    n_state = (r_state == S_E_MUL_BASE) ? S_E_NEXT : S_D_NEXT;
                end
            end
            S_E_NEXT, S_D_NEXT: begin
                if (r_n == '0) begin
                    n_acc = '0;
                    n_ex = '0;
                end
                if (r_n != '0 && r_ex != '0) begin
                    if (r_ex[0]) begin
                        n_state = (r_state == S_E_NEXT) ? S_E_MUL_ACC : S_D_MUL_ACC;
                    end else begin
                        n_state = (r_state == S_E_NEXT) ? S_E_MUL_BASE : S_D_MUL_BASE;
                    end
                end else if (r_state == S_E_NEXT) begin
                    n_c = (r_n == '0) ? '0 : r_acc;
                    n_x = MOD_BITS'(2);
                    n_state = S_F_SQ;
                end else begin
                    n_m = r_acc;
                    n_st = ST_OK;
                    n_state = S_OUT;
                end
            end
            S_F_INIT: begin
                n_x = MOD_BITS'(2);
                n_state = S_F_SQ;
            end
            S_F_SQ: begin
                // Candidate runs while x*x stays within n.
                if (w_sq > WIDE_BITS'(r_n)) begin
                    n_p = '0; n_q = '0; n_d = '0; n_m = '0;
                    n_st = ST_NO_FACTOR;
                    n_state = S_OUT;
                end else begin
                    n_state = S_F_DIV;
                end
            end
            S_F_DIV: begin
                w_req.num = WIDE_BITS'(r_n);
                w_req.den = r_x;
                if (!r_wait) begin
                    w_req.start = 1'b1;
                    n_wait = 1'b1;
                end else if (w_rsp.done) begin
                    n_wait = 1'b0;
                    if (w_rsp.rem == '0) begin
                        n_rest = w_rsp.quo[MOD_BITS-1:0];
                        n_state = S_F_STRIP;
                    end else begin
                        n_state = S_F_NEXT;
                    end
                end
            end
            S_F_STRIP: begin
                // Remove every power of x from the cofactor.
                w_req.num = WIDE_BITS'(r_rest);
                w_req.den = r_x;
                if (!r_wait) begin
                    w_req.start = 1'b1;
                    n_wait = 1'b1;
                end else if (w_rsp.done) begin
                    n_wait = 1'b0;
                    if (w_rsp.rem == '0) begin
                        n_rest = w_rsp.quo[MOD_BITS-1:0];
                    end else if (r_rest > MOD_BITS'(1)) begin
                        n_p = r_x;
                        n_state = S_Q_DIV;
                    end else begin
                        n_state = S_F_NEXT;
                    end
                end
            end
            S_F_NEXT: begin
                n_x = r_x + 1'b1;
                n_state = S_F_SQ;
            end
            S_Q_DIV: begin
                w_req.num = WIDE_BITS'(r_n);
                w_req.den = r_p;
                if (!r_wait) begin
                    w_req.start = 1'b1;
                    n_wait = 1'b1;
                end else if (w_rsp.done) begin
                    n_wait = 1'b0;
                    n_q = w_rsp.quo[MOD_BITS-1:0];
                    n_state = S_I_INIT;
                end
            end
            S_I_INIT: begin
                n_phi = MOD_BITS'(WIDE_BITS'(r_p - 1'b1) * WIDE_BITS'(r_q - 1'b1));
                n_i = MOD_BITS'(1);
                n_state = S_I_NEXT;
            end
            S_I_NEXT: begin
                if (r_i >= r_phi) begin
                    n_d = '0; n_m = '0;
                    n_st = ST_NO_INVERSE;
                    n_state = S_OUT;
                end else begin
                    n_state = S_I_MUL;
                end
            end
            S_I_MUL: begin
                w_req.num = WIDE_BITS'(r_i) * WIDE_BITS'(r_e);
                w_req.den = r_phi;
                if (!r_wait) begin
                    w_req.start = 1'b1;
                    n_wait = 1'b1;
                end else if (w_rsp.done) begin
                    n_wait = 1'b0;
                    if (w_rsp.rem == WIDE_BITS'(1)) begin
                        n_d = r_i;
                        n_base = r_c;
                        n_ex = r_i;
                        n_state = S_D_INIT;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = S_I_NEXT;
                    end
                end
            end
            S_OUT: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait <= n_wait;
        end
        r_n <= n_n; r_e <= n_e; r_acc <= n_acc; r_base <= n_base; r_ex <= n_ex;
        r_c <= n_c; r_x <= n_x; r_rest <= n_rest; r_p <= n_p; r_q <= n_q;
        r_phi <= n_phi; r_i <= n_i; r_d <= n_d; r_m <= n_m; r_st <= n_st;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_p = r_p[PF_BITS-1:0];
    assign o_q = r_q[Q_BITS-1:0];
    assign o_d = r_d;
    assign o_c = r_c;
    assign o_m = r_m;
    assign o_status = r_st;

endmodule
`default_nettype wire

### rtl/core/textbook_rsa_key_and_crypt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// textbook_rsa_key_and_crypt: small-modulus RSA key derivation and crypt.
// Factors n by trial division, derives d, encrypts and decrypts a message.
// ----------------------------------------------------------------------------
// One message is processed at a time. The block factors n by trial division,
// derives d by searching the inverse of e modulo phi, and runs both modular
// exponentiations, with every division on one shift-subtract divider. An item
// makes one divider call per candidate factor and more while a factor found is
// stripped, one per inverse candidate, and up to two per exponent bit. The
// input stall is high while an item is in work or its result waits;
// configuration writes are taken at any time and used by the next
// transaction.
module textbook_rsa_key_and_crypt (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire  [trsa_pkg::MOD_BITS-1:0]  i_message,
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic [trsa_pkg::PF_BITS-1:0]   o_small_factor,
    output logic [trsa_pkg::Q_BITS-1:0]    o_cofactor,
    output logic [trsa_pkg::MOD_BITS-1:0]  o_private_exponent,
    output logic [trsa_pkg::MOD_BITS-1:0]  o_ciphertext,
    output logic [trsa_pkg::MOD_BITS-1:0]  o_recovered,
    output logic [1:0]                     o_status,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [0:0]                     i_cfg_index,
    input  wire  [15:0]                    i_cfg_data
);
    import trsa_pkg::*;

    logic [MOD_BITS-1:0] r_modulus, r_exponent;
    logic w_busy, w_accept;
    t_status w_status;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= RST_MODULUS;
            r_exponent <= RST_EXPONENT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_MODULUS) begin
                r_modulus <= MOD_BITS'(i_cfg_data);
            end else begin
                r_exponent <= MOD_BITS'(i_cfg_data);
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_stall = w_busy;
    assign w_accept = i_valid && !w_busy;

    trsa_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_msg    (i_message),
        .i_n      (r_modulus),
        .i_e      (r_exponent),
        .i_take   (!i_stall),
        .o_busy   (w_busy),
        .o_valid  (o_valid),
        .o_p      (o_small_factor),
        .o_q      (o_cofactor),
        .o_d      (o_private_exponent),
        .o_c      (o_ciphertext),
        .o_m      (o_recovered),
        .o_status (w_status)
    );

    assign o_status = w_status;

    // A result is only shown while the sequencer is busy.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("result without busy sequencer");

    // A delivered result frees the input side next cycle.
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> !o_stall) else $error("input not released");

    // A factor failure reports a zero small factor.
    a_nofactor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NO_FACTOR) |-> (o_small_factor == '0))
        else $error("factor reported with no-factor status");

endmodule
`default_nettype wire

### test/tb_textbook_rsa_key_and_crypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_textbook_rsa_key_and_crypt: self-checking bench for the small-modulus RSA
// Sends messages under a series of key settings and checks every result.
// The bench predicts the factor pair, private exponent, ciphertext and
// recovered message in its own key model. Results are compared field by field
// in order. Both sides idle at random in two of three random phases. One
// long receiver hold-off fills the block so that it stalls its input.
// ----------------------------------------------------------------------------
module tb_textbook_rsa_key_and_crypt;
    import trsa_pkg::*;

    // Expected contents of one result transaction.
    typedef struct {
        logic [PF_BITS-1:0]  small_factor;
        logic [Q_BITS-1:0]   cofactor;
        logic [MOD_BITS-1:0] private_exponent;
        logic [MOD_BITS-1:0] ciphertext;
        logic [MOD_BITS-1:0] recovered;
        t_status             status;
    } t_crypt_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [MOD_BITS-1:0] i_message;
    logic                o_valid;
    logic                i_stall;
    logic [PF_BITS-1:0]  o_small_factor;
    logic [Q_BITS-1:0]   o_cofactor;
    logic [MOD_BITS-1:0] o_private_exponent;
    logic [MOD_BITS-1:0] o_ciphertext;
    logic [MOD_BITS-1:0] o_recovered;
    logic [1:0]          o_status;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [0:0]          i_cfg_index;
    logic [15:0]         i_cfg_data;

    // Key registers as the bench believes them to be.
    longint unsigned key_modulus;
    longint unsigned key_exponent;

    t_crypt_result pending_results[$];
    int            tx_idle_pct;
    int            rx_idle_pct;
    int            hold_request;
    int            hold_left;
    int            mismatches;
    int            results_seen;
    int            messages_sent;
    int            key_settings;

    textbook_rsa_key_and_crypt DUT (.*);

    // Clock with a 20 ns period.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Modular exponentiation with exact products.
    function automatic longint unsigned mod_power(longint unsigned base,
                                                   longint unsigned ex,
                                                   longint unsigned n);
        longint unsigned acc;
        if (n == 0) return 0;
        acc = 1 % n;
        base = base % n;
        while (ex != 0) begin
            if (ex[0]) acc = (acc * base) % n;
            base = (base * base) % n;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    // Smallest prime factor whose full removal leaves a cofactor above one.
    function automatic longint unsigned smallest_factor(longint unsigned n);
        longint unsigned rest;
        for (longint unsigned x = 2; x * x <= n; x++) begin
            if (n % x == 0) begin
                rest = n;
                while (rest % x == 0) rest = rest / x;
                if (rest > 1) return x;
            end
        end
        return 0;
    endfunction

    // Derives the key pair from the current settings and runs both directions.
    function automatic t_crypt_result derive_and_crypt(logic [MOD_BITS-1:0] msg);
        t_crypt_result   r;
        longint unsigned p, q, phi, d, c, m;
        q = 0;
        d = 0;
        m = 0;
        c = mod_power(msg, key_exponent, key_modulus);
        p = smallest_factor(key_modulus);
        if (p == 0) begin
            r.status = ST_NO_FACTOR;
        end else begin
            q = key_modulus / p;
            phi = (p - 1) * (q - 1);
            for (longint unsigned i = 1; i < phi; i++) begin
                if ((i * key_exponent) % phi == 1) begin
                    d = i;
                    break;
                end
            end
            if (d == 0) begin
                r.status = ST_NO_INVERSE;
            end else begin
                r.status = ST_OK;
                m = mod_power(c, d, key_modulus);
            end
        end
        r.small_factor = p[PF_BITS-1:0];
        r.cofactor = q[Q_BITS-1:0];
        r.private_exponent = d[MOD_BITS-1:0];
        r.ciphertext = c[MOD_BITS-1:0];
        r.recovered = m[MOD_BITS-1:0];
        return r;
    endfunction

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_left <= 0;
        end else if (hold_request > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_request;
            hold_request = 0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Checks each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_crypt_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transaction");
            end else begin
                want = pending_results.pop_front();
                if (o_small_factor !== want.small_factor || o_cofactor !== want.cofactor ||
                    o_private_exponent !== want.private_exponent ||
                    o_ciphertext !== want.ciphertext || o_recovered !== want.recovered ||
                    o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch n=%0d e=%0d: exp p=%0d q=%0d d=%0d c=%0d m=%0d st=%0d",
                                 key_modulus, key_exponent, want.small_factor,
                                 want.cofactor, want.private_exponent, want.ciphertext,
                                 want.recovered, want.status);
                        $display("    got p=%0d q=%0d d=%0d c=%0d m=%0d st=%0d",
                                 o_small_factor, o_cofactor, o_private_exponent,
                                 o_ciphertext, o_recovered, o_status);
                    end
                end
            end
        end
    end

    // Sends one message, with a random idle gap ahead of it.
    task automatic send_message(logic [MOD_BITS-1:0] msg);
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_message <= msg;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(derive_and_crypt(msg));
        messages_sent++;
    endtask

    // Waits for every outstanding result, then lets the block settle.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Writes both key registers while the block is idle.
    task automatic load_keys(logic [15:0] n, logic [15:0] e);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_MODULUS;
        i_cfg_data <= n;
        do @(posedge i_clk); while (!o_cfg_ready);
        key_modulus = n;
        i_cfg_index <= REG_EXPONENT;
        i_cfg_data <= e;
        do @(posedge i_clk); while (!o_cfg_ready);
        key_exponent = e;
        i_cfg_valid <= 1'b0;
        key_settings++;
        @(posedge i_clk);
    endtask

    // Messages under the reset key.
    task automatic test_reset_key();
        send_message(16'd65);
        send_message(16'd65535);
    endtask

    // Field extremes and each special case of the key derivation.
    task automatic test_corner_keys();
        load_keys(16'd65535, 16'd1);
        send_message(16'd0);
        send_message(16'd65535);
        send_message(16'd1);
        load_keys(16'd65521, 16'd65535);
        send_message(16'd12345);
        send_message(16'd65535);
        load_keys(16'd0, 16'd5);
        send_message(16'd7);
        load_keys(16'd1, 16'd0);
        send_message(16'd9);
        load_keys(16'd2, 16'd3);
        send_message(16'd3);
        load_keys(16'd3, 16'd2);
        send_message(16'd5);
        load_keys(16'd4, 16'd3);
        send_message(16'd3);
        load_keys(16'd6, 16'd1);
        send_message(16'd5);
        load_keys(16'd15, 16'd0);
        send_message(16'd4);
        load_keys(16'd15, 16'd2);
        send_message(16'd4);
        load_keys(16'd143, 16'd7);
        send_message(16'd42);
        send_message(16'd43690);
        load_keys(16'd391, 16'd65535);
        send_message(16'd21845);
    endtask

    // Random keys; most moduli stay small to bound the inverse search.
    task automatic random_keys();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            load_keys(16'($urandom_range(3)), 16'($urandom));
        else if (sel < 20)
            load_keys(16'($urandom), 16'd1);
        else if (sel < 35)
            load_keys(16'($urandom_range(4, 400)), 16'($urandom_range(0, 20)));
        else
            load_keys(16'($urandom_range(4, 400)), 16'($urandom));
    endtask

    // One idle phase of random keys and random messages.
    task automatic test_random_phase(int tx_pct, int rx_pct, int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int k = 0; k < count; k++) begin
            if (k % 8 == 0) random_keys();
            send_message(16'($urandom));
        end
    endtask

    // The receiver holds off longer than one transaction takes, so that a
    // finished result waits and the block stalls its input.
    task automatic test_backpressure();
        load_keys(16'd221, 16'd5);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 8000;
        for (int k = 0; k < 6; k++) send_message(16'($urandom));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_message = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_MODULUS;
        i_cfg_data = '0;
        key_modulus = RST_MODULUS;
        key_exponent = RST_EXPONENT;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 0;
        mismatches = 0;
        results_seen = 0;
        messages_sent = 0;
        key_settings = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_key();
        test_corner_keys();
        test_random_phase(35, 46, 88);
        test_random_phase(46, 35, 88);
        test_random_phase(0, 0, 88);
        test_backpressure();
        drain_results();

        $display("Sent %0d messages under %0d key settings, checked %0d results.",
                 messages_sent, key_settings, results_seen);
        $display("Covered missing factors, missing inverses, zero modulus and exponent.");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("Mismatches: %0d", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Guard against a hung block.
    initial begin
        #1_000_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
